[design/lbe_pkg.sv]
`default_nettype none

package lbe_pkg;

    localparam int COEF_FRAC = 22;
    localparam int COEF_W    = 24;
    localparam int X_W       = 16;
    localparam int VAL_W     = 18;
    localparam int IDX_W     = 5;
    localparam int TAB_DEPTH = 1 << IDX_W;
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = COEF_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int VAL_MAX   = 131071;
    localparam int VAL_MIN   = -131072;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_DEGREE = 1'b0;

    typedef logic [COEF_W-1:0] coef_t;
    typedef coef_t coef_tab_t [TAB_DEPTH];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT0,
        ST_S3,
        ST_XP,
        ST_AXP,
        ST_BP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } res_t;

    // floor(sqrt(num/den) * 2^COEF_FRAC), by bitwise root search
    function automatic coef_t coef_root(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] lim;
        logic [127:0] sq;
        coef_t        r;
        coef_t        t;
        int           i;
        lim = {64'd0, num} << (2 * COEF_FRAC);
        r   = '0;
        for (i = COEF_W - 1; i >= 0; i--)
        begin
            t  = r | (coef_t'(1) << i);
            sq = 128'(t) * 128'(t) * 128'(den);
            if (sq <= lim)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    // A(n) = sqrt((2n+1)(2n+3))/(n+1)
    function automatic coef_tab_t build_coef_a();
        coef_tab_t    tab;
        logic [63:0]  n;
        int           k;
        for (k = 0; k < TAB_DEPTH; k++)
        begin
            n      = 64'(k);
            tab[k] = coef_root((2 * n + 1) * (2 * n + 3), (n + 1) * (n + 1));
        end
        return tab;
    endfunction

    // B(n) = n*sqrt((2n+3)/(2n-1))/(n+1); unused at n = 0
    function automatic coef_tab_t build_coef_b();
        coef_tab_t    tab;
        logic [63:0]  n;
        int           k;
        tab[0] = '0;
        for (k = 1; k < TAB_DEPTH; k++)
        begin
            n      = 64'(k);
            tab[k] = coef_root(n * n * (2 * n + 3), (2 * n - 1) * (n + 1) * (n + 1));
        end
        return tab;
    endfunction

    localparam coef_tab_t COEF_A_TAB = build_coef_a();
    localparam coef_tab_t COEF_B_TAB = build_coef_b();
    localparam coef_t     SQRT3_Q    = coef_root(64'd3, 64'd1);

    // P0 = 1.0, saturated when 2^frac is out of range
    function automatic logic signed [VAL_W-1:0] p0_value(input int frac);
        logic signed [VAL_W-1:0] v;
        if (frac >= VAL_W - 1)
        begin
            v = VAL_W'(VAL_MAX);
        end
        else
        begin
            v = VAL_W'(1 << frac);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[design/lbe_mul.sv]
`default_nettype none

module lbe_mul import lbe_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]       prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

endmodule

`default_nettype wire

[design/lbe_seq.sv]
`default_nettype none

module lbe_seq import lbe_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [X_W-1:0] x_in,
    input  wire logic [IDX_W-1:0]      deg_in,
    output logic                       busy,
    output res_t                       res,
    input  wire logic                  res_ready
);

    localparam logic signed [VAL_W-1:0]  P0_VAL = p0_value(FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(64'd1 << (COEF_FRAC - 1));
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(VAL_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(VAL_MIN);

    state_t                     state_reg;
    state_t                     state_next;
    logic signed [X_W-1:0]      x_reg;
    logic [IDX_W-1:0]           d_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_inc;
    logic signed [VAL_W-1:0]    prev_reg;
    logic signed [VAL_W-1:0]    cur_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   fin_sum;
    logic signed [PROD_W-1:0]   fin_shift;
    logic signed [VAL_W-1:0]    fin_val;

    lbe_mul u_mul
    (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    assign idx_inc = IDX_W'(idx_reg + 1'b1);
    assign busy    = (state_reg != ST_IDLE);

    // acc holds round(A*x*P(n) >> F); prod holds B*P(n-1)
    always_comb
    begin
        fin_sum   = acc_reg - prod_reg + HALF_C;
        fin_shift = fin_sum >>> COEF_FRAC;
        if (fin_shift > SAT_HI)
        begin
            fin_val = VAL_W'(VAL_MAX);
        end
        else if (fin_shift < SAT_LO)
        begin
            fin_val = VAL_W'(VAL_MIN);
        end
        else
        begin
            fin_val = fin_shift[VAL_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        res        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EMIT0;
                end
            end
            ST_EMIT0:
            begin
                res.valid = 1'b1;
                res.index = '0;
                res.value = P0_VAL;
                res.last  = (d_reg == '0);
                if (res_ready)
                begin
                    state_next = (d_reg == '0) ? ST_IDLE : ST_S3;
                end
            end
            ST_S3:
            begin
                // negated so that FIN's acc - prod gives +sqrt3*x
                mul_en     = 1'b1;
                mul_a      = -(MUL_A_W'(x_reg));
                mul_b      = signed'({1'b0, SQRT3_Q});
                state_next = ST_FIN;
            end
            ST_XP:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cur_reg);
                mul_b      = MUL_B_W'(x_reg);
                state_next = ST_AXP;
            end
            ST_AXP:
            begin
                mul_en     = 1'b1;
                mul_a      = prod_reg[MUL_A_W-1:0];
                mul_b      = signed'({1'b0, COEF_A_TAB[idx_reg]});
                state_next = ST_BP;
            end
            ST_BP:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(prev_reg);
                mul_b      = signed'({1'b0, COEF_B_TAB[idx_reg]});
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                res.valid = 1'b1;
                res.index = idx_inc;
                res.value = fin_val;
                res.last  = (idx_inc == d_reg);
                if (res_ready)
                begin
                    state_next = (idx_inc == d_reg) ? ST_IDLE : ST_XP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            x_reg <= x_in;
            d_reg <= deg_in;
        end
        if (state_reg == ST_EMIT0)
        begin
            cur_reg <= P0_VAL;
            idx_reg <= '0;
        end
        if (state_reg == ST_S3)
        begin
            acc_reg <= '0;
        end
        if (state_reg == ST_BP)
        begin
            acc_reg <= (prod_reg + HALF_F) >>> FRAC_BITS;
        end
        if ((state_reg == ST_FIN) && res_ready)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= fin_val;
            idx_reg  <= idx_inc;
        end
    end

endmodule

`default_nettype wire

[design/legendre_basis_evaluator.sv]
`default_nettype none

// Orthonormal Legendre basis evaluator. Each input transaction carries one
// point x_point (signed, FRAC_BITS fraction bits, nominally in [-1,1]); the
// block answers with degree+1 output transactions P0..Pd in order, each with
// its degree in poly_index, the value in poly_value (signed, FRAC_BITS
// fraction bits, saturated to 18 bits) and last set on the final one.
// Degree is the only register (APB offset 0, 5 bits, reset 31) and is
// clamped to MAX_DEGREE; write it only while the block is idle. Values use
// P(n+1) = A(n)*x*P(n) - B(n)*P(n-1) with A, B held in a 22-fraction-bit
// constant table; rounding is to nearest, ties up. One signed 35x25
// multiplier is shared by every step: P0 needs none, P1 is sqrt3*x and each
// higher degree steps through x*P, A*xP, B*Pprev, round and saturate. A
// point keeps the sequencer busy until its last result is handed to the
// output register, and only then can a new point be taken. in_stall is
// high for the whole of that time; a result waits in the output register
// while the sequencer prepares the next one.
module legendre_basis_evaluator import lbe_pkg::*;
#(
    parameter int MAX_DEGREE = 31,
    parameter int FRAC_BITS  = 14
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [X_W-1:0]   x_point,
    // output channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [IDX_W-1:0]             poly_index,
    output logic signed [VAL_W-1:0]      poly_value,
    output logic                         last,
    // configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int               IDX_MAX = (1 << IDX_W) - 1;
    localparam int               DEG_CAP = (MAX_DEGREE > IDX_MAX) ? IDX_MAX : MAX_DEGREE;
    localparam logic [IDX_W-1:0] DEG_LIM = IDX_W'(DEG_CAP);
    localparam logic signed [VAL_W-1:0] P0_VAL = p0_value(FRAC_BITS);

    logic [IDX_W-1:0]        degree_reg;
    logic [IDX_W-1:0]        deg_eff;
    logic                    cfg_wr;
    logic                    start;
    logic                    busy;
    logic                    res_ready;
    res_t                    res;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        poly_index_reg;
    logic signed [VAL_W-1:0] poly_value_reg;
    logic                    last_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEGREE);
    assign prdata = (paddr[2] == REG_DEGREE) ? DATA_W'(degree_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= IDX_W'(IDX_MAX);
        end
        else if (cfg_wr)
        begin
            degree_reg <= pwdata[IDX_W-1:0];
        end
    end

    assign deg_eff = (degree_reg > DEG_LIM) ? DEG_LIM : degree_reg;

    // ---------------- sequencer and shared multiplier ----------------
    // one point in flight; new transaction taken only when sequencer is idle
    assign start    = in_valid && !busy;
    assign in_stall = busy;

    lbe_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .x_in      (x_point),
        .deg_in    (deg_eff),
        .busy      (busy),
        .res       (res),
        .res_ready (res_ready)
    );

    // ---------------- output register ----------------
    // loads when empty or when the held transaction leaves this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            poly_index_reg <= res.index;
            poly_value_reg <= res.value;
            last_reg       <= res.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign poly_index = poly_index_reg;
    assign poly_value = poly_value_reg;
    assign last       = last_reg;

    // ---------------- assertions ----------------
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (poly_index == deg_eff))
        else $error("last flag on a degree other than the configured one");

    a_p0_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (poly_index == '0)) |-> (poly_value == P0_VAL))
        else $error("degree zero result is not P0");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer not busy after taking a point");

    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> in_stall)
        else $error("sequencer idle while results of a point remain");

endmodule

`default_nettype wire

[test/legendre_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the APB port, predicts the basis values for
// each accepted point and compares them in order.
module legendre_checker import lbe_pkg::*;
#(
    parameter int MAX_DEGREE = 31,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [X_W-1:0]   x_point,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [IDX_W-1:0]        poly_index,
    input  logic signed [VAL_W-1:0] poly_value,
    input  logic                    last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic [DATA_W-1:0]       prdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      outstanding,
    output int                      values_checked
);

    localparam logic [IDX_W-1:0] DEGREE_RESET = 5'd31;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } basis_value_t;

    basis_value_t     expected_values [$];
    logic [IDX_W-1:0] degree_shadow = DEGREE_RESET;

    // recurrence coefficients, 22 fraction bits, truncated
    longint sqrt3_q;
    longint coef_a_q [MAX_DEGREE];
    longint coef_b_q [MAX_DEGREE];

    initial
    begin
        fail_count     = 0;
        outstanding    = 0;
        values_checked = 0;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        int              i;
        r = 0;
        for (i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    // nearest, ties toward +inf
    function automatic longint round_frac(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_value(input longint v);
        if (v > VAL_MAX)
        begin
            return VAL_MAX;
        end
        if (v < VAL_MIN)
        begin
            return VAL_MIN;
        end
        return v;
    endfunction

    initial
    begin
        longint unsigned n;
        int              k;
        sqrt3_q = root_floor(64'd3 << (2 * COEF_FRAC));
        coef_a_q[0] = 0;
        coef_b_q[0] = 0;
        for (k = 1; k < MAX_DEGREE; k++)
        begin
            n = k;
            coef_a_q[k] = root_floor((((2 * n + 1) * (2 * n + 3)) << (2 * COEF_FRAC))
                                     / ((n + 1) * (n + 1)));
            coef_b_q[k] = root_floor(((n * n * (2 * n + 3)) << (2 * COEF_FRAC))
                                     / ((2 * n - 1) * (n + 1) * (n + 1)));
        end
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
        begin
            $display("[%0t] check: %s", $time, what);
        end
    endtask

    task automatic queue_value(input int n, input longint v, input int top);
        basis_value_t item;
        item.index = n[IDX_W-1:0];
        item.value = v[VAL_W-1:0];
        item.last  = (n == top);
        expected_values.push_back(item);
    endtask

    // P0..Pd for one point
    task automatic expand_basis(input logic signed [X_W-1:0] x);
        longint xv;
        longint prev;
        longint cur;
        longint nxt;
        longint t1;
        longint t2;
        int     d;
        int     n;
        d  = degree_shadow;
        if (d > MAX_DEGREE)
        begin
            d = MAX_DEGREE;
        end
        xv   = x;
        prev = clip_value(longint'(1) <<< FRAC_BITS);
        queue_value(0, prev, d);
        if (d == 0)
        begin
            return;
        end
        cur = clip_value(round_frac(sqrt3_q * xv, COEF_FRAC));
        queue_value(1, cur, d);
        for (n = 1; n < d; n++)
        begin
            t1   = round_frac(coef_a_q[n] * xv * cur, FRAC_BITS);
            t2   = coef_b_q[n] * prev;
            nxt  = clip_value(round_frac(t1 - t2, COEF_FRAC));
            queue_value(n + 1, nxt, d);
            prev = cur;
            cur  = nxt;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        basis_value_t want;
        if (!rst_n)
        begin
            degree_shadow = DEGREE_RESET;
            expected_values.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_DEGREE)
            begin
                if (pwrite)
                begin
                    degree_shadow = pwdata[IDX_W-1:0];
                end
                else if (prdata[IDX_W-1:0] !== degree_shadow)
                begin
                    report_mismatch($sformatf("degree read %0d, expected %0d",
                                              prdata[IDX_W-1:0], degree_shadow));
                end
            end
            if (in_valid && !in_stall)
            begin
                expand_basis(x_point);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result index %0d value %0d",
                                              poly_index, poly_value));
                end
                else
                begin
                    want = expected_values.pop_front();
                    values_checked++;
                    if (poly_index !== want.index)
                    begin
                        report_mismatch($sformatf("poly_index %0d, expected %0d",
                                                  poly_index, want.index));
                    end
                    if (poly_value !== want.value)
                    begin
                        report_mismatch($sformatf("P%0d value %0d, expected %0d",
                                                  want.index, poly_value, want.value));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("P%0d last %b, expected %b",
                                                  want.index, last, want.last));
                    end
                end
            end
        end
        outstanding = expected_values.size();
    end

endmodule

[test/tb_legendre_basis_evaluator.sv]
`timescale 1ns / 100ps

// Top of the Legendre basis testbench: clock, reset, stimulus and verdict.
// All checking lives in legendre_checker.
module tb_legendre_basis_evaluator;
    import lbe_pkg::*;

    localparam int POINTS_PER_PHASE = 23;
    localparam int RANDOM_PHASES    = 6;
    // degree is register 0; paddr[2] selects the register
    localparam logic [ADDR_W-1:0] DEGREE_ADDR = {REG_DEGREE, 2'b00};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic signed [X_W-1:0]   x_point   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [IDX_W-1:0]        poly_index;
    logic signed [VAL_W-1:0] poly_value;
    logic                    last;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [ADDR_W-1:0]       paddr     = '0;
    logic [DATA_W-1:0]       pwdata    = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int fail_count;
    int outstanding;
    int values_checked;

    // sender burst shaping
    int burst_left     = 0;
    int points_sent    = 0;
    int settings_used  = 0;

    // receiver stall pattern
    int stall_mode     = 0;
    int stall_left     = 0;

    always #5 clk = ~clk;

    legendre_basis_evaluator DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_point    (x_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .poly_index (poly_index),
        .poly_value (poly_value),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    legendre_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .x_point        (x_point),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .poly_index     (poly_index),
        .poly_value     (poly_value),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .values_checked (values_checked)
    );

    // Receiver: stall behavior switches at random between modes: never stalled,
    // light random, heavy random, and regular periodic holds.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= (stall_left[3:2] == 2'b11);
        endcase
    end

    // One APB transfer: setup phase, then access until pready, then an idle
    // phase. Called at a falling edge, returns at a falling edge.
    task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected value has come back and the
    // block stops stalling its input.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0 || in_stall)
        begin
            @(negedge clk);
        end
    endtask

    // Reprogram degree while idle, then read it back (checker compares).
    task automatic set_degree(input logic [IDX_W-1:0] deg);
        wait_idle();
        apb_xfer(1'b1, DEGREE_ADDR, DATA_W'(deg));
        apb_xfer(1'b0, DEGREE_ADDR, '0);
        settings_used++;
    endtask

    // One input transaction. Valid stays up across a burst; between bursts
    // it drops for a random gap, so no step ever sees valid lowered and
    // raised together.
    task automatic send_point(input logic signed [X_W-1:0] x);
        in_valid <= 1'b1;
        x_point  <= x;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        points_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            // every so often a long burst with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 6);
        end
    endtask

    initial
    begin
        int                    phase;
        int                    k;
        int                    v;
        logic [IDX_W-1:0]      deg;
        logic signed [X_W-1:0] x;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset value of degree (31): read back, then the corners of the
        // point range, including points past +-1 that saturate high degrees.
        apb_xfer(1'b0, DEGREE_ADDR, '0);
        settings_used++;
        send_point(16'sd16384);
        send_point(-16'sd16384);
        send_point(16'sd0);
        send_point(16'sd1);
        send_point(-16'sd1);
        send_point(16'sd8192);
        send_point(16'sh7FFF);
        send_point(16'sh8000);

        // Degree zero: P0 alone, flagged last.
        set_degree(5'd0);
        send_point(16'sd16384);
        send_point(16'sh5555);
        send_point(16'shAAAA);

        // Degree one: P0 and P1 only, P1 at the widest inputs.
        set_degree(5'd1);
        send_point(-16'sd16384);
        send_point(16'sh7FFF);
        send_point(16'sh8000);

        // Degree two: first use of the recurrence, P2 saturates at x = 2.
        set_degree(5'd2);
        send_point(16'sd16384);
        send_point(-16'sd16384);
        send_point(16'sh7FFF);
        send_point(16'sd12345);

        // Random phases: mostly points inside [-1,1], some anywhere in range.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       deg = 5'd31;
                1:       deg = 5'd0;
                2:       deg = 5'd1;
                3:       deg = IDX_W'($urandom_range(2, 30));
                4:       deg = IDX_W'($urandom_range(0, 31));
                default: deg = 5'd31;
            endcase
            set_degree(deg);
            for (k = 0; k < POINTS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    x = X_W'($urandom);
                end
                else
                begin
                    v = int'($urandom_range(0, 32768)) - 16384;
                    x = v[X_W-1:0];
                end
                send_point(x);
            end
        end

        wait_idle();
        // settle: catch any stray result after the last expected one
        repeat (20) @(negedge clk);

        $display("covered %0d points over %0d degree settings, inputs across the full range",
                 points_sent, settings_used);
        $display("%0d basis values compared against the recurrence", values_checked);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
design/lbe_pkg.sv
design/lbe_mul.sv
design/lbe_seq.sv
design/legendre_basis_evaluator.sv
test/legendre_checker.sv
test/tb_legendre_basis_evaluator.sv
